[src/bdpcm_ra_pkg.sv]
// Shared types and constants for the BDPCM residual accumulation block.
// No dependencies; used by every module under src.
`timescale 1ns / 1ps

package bdpcm_ra_pkg;

  localparam int MAX_WIDTH_DEF      = 32;
  localparam int MAX_RANGE_BITS_DEF = 20;
  localparam int COEFF_W            = 21;
  localparam int MAX_HEIGHT         = 32;
  localparam int MIN_RANGE_BITS     = 15;
  localparam int PADDR_W            = 4;
  localparam int PDATA_W            = 32;

  localparam logic [5:0] WIDTH_RST  = 6'd4;
  localparam logic [5:0] HEIGHT_RST = 6'd4;
  localparam logic       VERT_RST   = 1'b0;
  localparam logic [4:0] RANGE_RST  = 5'd15;

  typedef enum logic [1:0] {
    REG_BLOCK_WIDTH   = 2'd0,
    REG_BLOCK_HEIGHT  = 2'd1,
    REG_VERTICAL_MODE = 2'd2,
    REG_RANGE_BITS    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [5:0] block_width;
    logic [5:0] block_height;
    logic       vertical_mode;
    logic [4:0] range_bits;
  } cfg_t;

  // Accumulator width: clipped sums need range_bits + 1 bits, never less than a coeff.
  function automatic int acc_width(input int max_range_bits);
    int w;
    w = max_range_bits + 1;
    if (w < COEFF_W) w = COEFF_W;
    return w;
  endfunction

endpackage

[src/bdpcm_ra_regs.sv]
// APB-style configuration registers for the BDPCM residual accumulation block.
// Depends on bdpcm_ra_pkg.
`timescale 1ns / 1ps

module bdpcm_ra_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bdpcm_ra_pkg::PADDR_W-1:0]     paddr,
  input  logic [bdpcm_ra_pkg::PDATA_W-1:0]     pwdata,
  output logic [bdpcm_ra_pkg::PDATA_W-1:0]     prdata,
  output logic                                 pready,
  output bdpcm_ra_pkg::cfg_t                   cfg,
  output logic                                 restart
);

  bdpcm_ra_pkg::reg_idx_t idx;
  logic                   wr;

  assign idx     = bdpcm_ra_pkg::reg_idx_t'(paddr[3:2]);
  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite && pready;
  assign restart = wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_width   <= bdpcm_ra_pkg::WIDTH_RST;
      cfg.block_height  <= bdpcm_ra_pkg::HEIGHT_RST;
      cfg.vertical_mode <= bdpcm_ra_pkg::VERT_RST;
      cfg.range_bits    <= bdpcm_ra_pkg::RANGE_RST;
    end else if (wr) begin
      case (idx)
        bdpcm_ra_pkg::REG_BLOCK_WIDTH:   cfg.block_width   <= pwdata[5:0];
        bdpcm_ra_pkg::REG_BLOCK_HEIGHT:  cfg.block_height  <= pwdata[5:0];
        bdpcm_ra_pkg::REG_VERTICAL_MODE: cfg.vertical_mode <= pwdata[0];
        bdpcm_ra_pkg::REG_RANGE_BITS:    cfg.range_bits    <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      bdpcm_ra_pkg::REG_BLOCK_WIDTH:   prdata[5:0] = cfg.block_width;
      bdpcm_ra_pkg::REG_BLOCK_HEIGHT:  prdata[5:0] = cfg.block_height;
      bdpcm_ra_pkg::REG_VERTICAL_MODE: prdata[0]   = cfg.vertical_mode;
      bdpcm_ra_pkg::REG_RANGE_BITS:    prdata[4:0] = cfg.range_bits;
      default: prdata = '0;
    endcase
  end

endmodule

[src/bdpcm_ra_row_store.sv]
// Row store: one accumulated value per column, registered read.
// Depends on bdpcm_ra_pkg (no direct use beyond widths passed in).
`timescale 1ns / 1ps

module bdpcm_ra_row_store #(
  parameter int DEPTH  = bdpcm_ra_pkg::MAX_WIDTH_DEF,
  parameter int DATA_W = bdpcm_ra_pkg::COEFF_W
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

[src/bdpcm_ra_accum.sv]
// Add-and-clip datapath: coeff plus predecessor, clipped to [-2^p, 2^p-1].
// Depends on bdpcm_ra_pkg.
`timescale 1ns / 1ps

module bdpcm_ra_accum #(
  parameter int ACC_W = bdpcm_ra_pkg::COEFF_W
) (
  input  logic signed [bdpcm_ra_pkg::COEFF_W-1:0] coeff,
  input  logic signed [ACC_W-1:0]                 prev,
  input  logic                                    pass,
  input  logic [4:0]                              clip_bits,
  output logic signed [ACC_W-1:0]                 result
);

  localparam logic [ACC_W:0] One = (ACC_W+1)'(1);

  logic signed [ACC_W:0]   sum;
  logic signed [ACC_W:0]   hi;
  logic signed [ACC_W:0]   lo;
  logic signed [ACC_W-1:0] coeff_x;

  assign coeff_x = {{(ACC_W-bdpcm_ra_pkg::COEFF_W+1){coeff[bdpcm_ra_pkg::COEFF_W-1]}},
                    coeff[bdpcm_ra_pkg::COEFF_W-2:0]};
  assign sum     = $signed({coeff_x[ACC_W-1], coeff_x}) + $signed({prev[ACC_W-1], prev});
  assign hi      = $signed((One << clip_bits) - One);
  assign lo      = ~hi;

  always_comb begin
    if (pass)          result = coeff_x;
    else if (sum > hi) result = hi[ACC_W-1:0];
    else if (sum < lo) result = lo[ACC_W-1:0];
    else               result = sum[ACC_W-1:0];
  end

endmodule

[src/bdpcm_residual_accumulate_unit.sv]
// Top level of the BDPCM residual accumulation block.
// Depends on bdpcm_ra_pkg, bdpcm_ra_regs, bdpcm_ra_row_store, bdpcm_ra_accum.
`timescale 1ns / 1ps

// Inverse block-DPCM accumulation of residual coefficients, one coefficient
// beat in, one result beat out. Coefficients arrive in raster order for a
// block_width x block_height block. Horizontal mode adds each coefficient to
// its accumulated left neighbor; vertical mode adds it to the accumulated value
// above it, held in a row store of MAX_WIDTH entries. Sums clip to
// [-2^range_bits, 2^range_bits-1]; the first column (horizontal) or first row
// (vertical) passes through. block_last flags the final beat of each block.
// Throughput is one beat per cycle while result_stall is low. An accepted
// input beat is loaded into the work register (coefficient plus the registered
// row store read) and moves on to the output register once that register is
// empty or its result is taken. A new input beat is taken while a finished
// result waits under result_stall only if the work register between the two
// is empty; with both full, coeff_stall follows result_stall. Any register
// write restarts the block at its first coefficient; write registers only
// while the block is idle. The row store needs no clearing: each block begins
// with a full first row, which writes every entry that later rows read.

module bdpcm_residual_accumulate_unit #(
  parameter int MAX_WIDTH      = bdpcm_ra_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RANGE_BITS = bdpcm_ra_pkg::MAX_RANGE_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  // coefficient input channel
  input  logic                                       coeff_valid,
  output logic                                       coeff_stall,
  input  logic signed [bdpcm_ra_pkg::COEFF_W-1:0]    coeff_in,
  // result channel
  output logic                                       result_valid,
  input  logic                                       result_stall,
  output logic signed [bdpcm_ra_pkg::COEFF_W-1:0]    coeff_out,
  output logic                                       block_last,
  // configuration port
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [bdpcm_ra_pkg::PADDR_W-1:0]           paddr,
  input  logic [bdpcm_ra_pkg::PDATA_W-1:0]           pwdata,
  output logic [bdpcm_ra_pkg::PDATA_W-1:0]           prdata,
  output logic                                       pready
);

  localparam int ACC_W = bdpcm_ra_pkg::acc_width(MAX_RANGE_BITS);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam logic [7:0] MaxW8   = 8'(MAX_WIDTH);
  localparam logic [4:0] RngMin  = 5'(bdpcm_ra_pkg::MIN_RANGE_BITS);
  localparam logic [4:0] RngMax  = 5'(MAX_RANGE_BITS);
  localparam logic [5:0] MaxH6   = 6'(bdpcm_ra_pkg::MAX_HEIGHT);

  bdpcm_ra_pkg::cfg_t cfg;
  logic               restart;

  bdpcm_ra_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .restart (restart)
  );

  // ---------------------------------------------------------------------------
  // Effective (clamped) configuration
  // ---------------------------------------------------------------------------
  logic [7:0] width_eff;
  logic [5:0] height_eff;
  logic [4:0] clip_bits;

  always_comb begin
    if (cfg.block_width == '0)              width_eff = 8'd1;
    else if ({2'b00, cfg.block_width} > MaxW8) width_eff = MaxW8;
    else                                     width_eff = {2'b00, cfg.block_width};

    if (cfg.block_height == '0)   height_eff = 6'd1;
    else if (cfg.block_height > MaxH6) height_eff = MaxH6;
    else                          height_eff = cfg.block_height;

    if (cfg.range_bits < RngMin)      clip_bits = RngMin;
    else if (cfg.range_bits > RngMax) clip_bits = RngMax;
    else                              clip_bits = cfg.range_bits;
  end

  // ---------------------------------------------------------------------------
  // Position counters, advanced on each accepted input beat
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0] column_pos, column_pos_next;
  logic [4:0]       row_pos, row_pos_next;
  logic [7:0]       col8;
  logic [COL_W-1:0] col;
  logic             last_col, last_beat, first_elem;
  logic             in_accept;

  always_comb begin
    col8 = 8'(column_pos);
    if (col8 >= width_eff) col8 = width_eff - 8'd1;
    col        = col8[COL_W-1:0];
    last_col   = (col8 + 8'd1) >= width_eff;
    last_beat  = last_col && ((6'(row_pos) + 6'd1) >= height_eff);
    first_elem = cfg.vertical_mode ? (row_pos == '0) : (col8 == 8'd0);

    column_pos_next = column_pos;
    row_pos_next    = row_pos;
    if (restart) begin
      column_pos_next = '0;
      row_pos_next    = '0;
    end else if (in_accept) begin
      if (last_beat) begin
        column_pos_next = '0;
        row_pos_next    = '0;
      end else if (last_col) begin
        column_pos_next = '0;
        row_pos_next    = row_pos + 5'd1;
      end else begin
        column_pos_next = col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos    <= '0;
    end else begin
      column_pos <= column_pos_next;
      row_pos    <= row_pos_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Work stage: holds the accepted beat while the row store read completes
  // ---------------------------------------------------------------------------
  logic                                    work_valid;
  logic signed [bdpcm_ra_pkg::COEFF_W-1:0] work_coeff;
  logic [COL_W-1:0]                        work_col;
  logic                                    work_pass, work_last, work_vert;
  logic                                    work_adv;
  logic                                    fwd_hit;
  logic signed [ACC_W-1:0]                 fwd_value;
  logic signed [ACC_W-1:0]                 left_value;
  logic signed [ACC_W-1:0]                 above, prev, result;
  logic [ACC_W-1:0]                        rd_data;
  logic                                    store_wr;

  assign work_adv    = work_valid && (!result_valid || !result_stall);
  assign coeff_stall = work_valid && !work_adv;
  assign in_accept   = coeff_valid && !coeff_stall;
  assign store_wr    = work_adv && work_vert;

  always_ff @(posedge clk) begin
    if (rst) work_valid <= 1'b0;
    else if (in_accept) work_valid <= 1'b1;
    else if (work_adv) work_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      work_coeff <= coeff_in;
      work_col   <= col;
      work_pass  <= first_elem;
      work_last  <= last_beat;
      work_vert  <= cfg.vertical_mode;
      // The beat leaving this cycle writes the entry we are reading: bypass it.
      fwd_hit    <= store_wr && (work_col == col);
      fwd_value  <= result;
    end
  end

  bdpcm_ra_row_store #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (ACC_W)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (work_col),
    .wr_data (result),
    .rd_en   (in_accept),
    .rd_addr (col),
    .rd_data (rd_data)
  );

  assign above = fwd_hit ? fwd_value : $signed(rd_data);
  assign prev  = work_vert ? above : left_value;

  bdpcm_ra_accum #(
    .ACC_W (ACC_W)
  ) u_accum (
    .coeff     (work_coeff),
    .prev      (prev),
    .pass      (work_pass),
    .clip_bits (clip_bits),
    .result    (result)
  );

  // Left neighbor for horizontal mode
  always_ff @(posedge clk) begin
    if (rst) left_value <= '0;
    else if (work_adv && !work_vert) left_value <= result;
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (work_adv) result_valid <= 1'b1;
    else if (!result_stall) result_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (work_adv) begin
      coeff_out  <= result[bdpcm_ra_pkg::COEFF_W-1:0];
      block_last <= work_last;
    end
  end

endmodule
